// ===== design/kls_pkg.sv =====
// shared types and constants for the streaming k-th largest selector
`default_nettype none

package kls_pkg;

  localparam int VALUE_W = 32;
  localparam int RANK_W  = 5;

  // what one cell hands to the next cell down the chain
  typedef struct packed {
    logic                       ge;     // cell holds a live value not below the new one
    logic                       vld;    // cell holds a live value
    logic signed [VALUE_W-1:0]  value;
  } link_t;

endpackage

`default_nettype wire

// ===== design/kls_if.sv =====
// valid/ready channel interfaces for the input and result streams
`default_nettype none

interface kls_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [kls_pkg::VALUE_W-1:0]    value;
  logic                                  last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface kls_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [kls_pkg::VALUE_W-1:0]    kth_value;
  logic                                  short_set;

  modport source (output valid, output kth_value, output short_set, input ready);
  modport sink   (input valid, input kth_value, input short_set, output ready);
endinterface

`default_nettype wire

// ===== design/kls_cell.sv =====
// one compare-and-shift cell of the sorted insertion chain
`default_nettype none

module kls_cell (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                en,
  input  wire logic                                ins,
  input  wire logic                                clr,
  input  wire logic signed [kls_pkg::VALUE_W-1:0]  din,
  input  wire kls_pkg::link_t                      prev,
  output kls_pkg::link_t                           link
);

  logic signed [kls_pkg::VALUE_W-1:0] val_r, val_nxt;
  logic                               vld_r, vld_nxt;
  logic                               effv;
  logic                               ge;

  // entries beyond the current rank count as empty
  assign effv = vld_r && en;
  assign ge   = effv && (val_r >= din);

  assign link.ge    = ge;
  assign link.vld   = effv;
  assign link.value = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ins && prev.ge && !ge) begin
      val_nxt = din;
    end else if (ins && !prev.ge) begin
      val_nxt = prev.value;
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (clr) begin
      vld_nxt = 1'b0;
    end else if (ins) begin
      vld_nxt = en && (effv || prev.vld);
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/streaming_kth_largest_select.sv =====
// top level of the streaming k-th largest selector
// Takes one signed 32-bit value per beat and keeps the k largest values of the
// current set in a chain of MAX_K compare cells sorted largest first; each beat
// every cell compares its entry with the new value and either keeps it, takes
// the new value, or takes its upper neighbor's entry. After a beat with
// last_item set, once any previous result has been taken, the chain's tail
// (the smallest kept value) is copied into the result register, short_set is
// raised when fewer than k values arrived, and all cells are emptied for the
// next set. New input is held off (in_bus.ready low) until then. rank_k is
// written through cfg_we/cfg_data; the user must write it only while the block
// is idle, which the block itself does not enforce; 0 acts as 1 and values above
// MAX_K act as MAX_K. A lowered rank simply masks the cells beyond it.
`default_nettype none

module streaming_kth_largest_select #(
  parameter int MAX_K = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [kls_pkg::RANK_W-1:0]    cfg_data,
  kls_in_if.sink                             in_bus,
  kls_out_if.source                          out_bus
);

  // configuration
  logic [kls_pkg::RANK_W-1:0] rank_r, rank_nxt;

  // report control: pend_r means a set has closed and its result is not yet loaded
  logic                               pend_r, pend_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic signed [kls_pkg::VALUE_W-1:0] kth_r, kth_nxt;
  logic                               short_r, short_nxt;

  logic ins;
  logic report;

  // chain wiring; link 0 is the virtual head that always wins the compare
  kls_pkg::link_t       links [MAX_K+1];
  logic [MAX_K:0]       cap_en;
  logic [MAX_K:0]       vld_vec;
  logic [MAX_K-1:0]     tail;
  logic [MAX_K-1:0]     cap_end;

  logic signed [kls_pkg::VALUE_W-1:0] tail_value;
  logic                               full;

  assign ins    = in_bus.valid && in_bus.ready;
  assign report = pend_r && (!out_valid_r || out_bus.ready);

  assign in_bus.ready      = !pend_r;
  assign out_bus.valid     = out_valid_r;
  assign out_bus.kth_value = kth_r;
  assign out_bus.short_set = short_r;

  assign links[0].ge    = 1'b1;
  assign links[0].vld   = 1'b1;
  assign links[0].value = '0;

  assign cap_en[MAX_K]  = 1'b0;
  assign vld_vec[MAX_K] = 1'b0;

  for (genvar i = 0; i < MAX_K; i++) begin : g_chain
    // cell i is in use when i < max(rank, 1); MAX_K bounds i already
    if (i == 0) begin : g_head
      assign cap_en[i] = 1'b1;
    end else begin : g_body
      assign cap_en[i] = ({{(32-kls_pkg::RANK_W){1'b0}}, rank_r} > 32'(i));
    end

    kls_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (cap_en[i]),
      .ins   (ins),
      .clr   (report),
      .din   (in_bus.value),
      .prev  (links[i]),
      .link  (links[i+1])
    );

    assign vld_vec[i] = links[i+1].vld;
    assign tail[i]    = vld_vec[i] && !vld_vec[i+1];
    assign cap_end[i] = cap_en[i] && !cap_en[i+1];
  end

  // the tail is one-hot over live cells, so an and-or mux picks it
  always_comb begin
    tail_value = '0;
    for (int i = 0; i < MAX_K; i++) begin
      tail_value = tail_value | (tail[i] ? links[i+1].value : '0);
    end
  end

  // store is full when the last cell within the rank is live
  assign full = |(vld_vec[MAX_K-1:0] & cap_end);

  always_comb begin
    rank_nxt = rank_r;
    if (cfg_we) begin
      rank_nxt = cfg_data;
    end
  end

  always_comb begin
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    kth_nxt       = kth_r;
    short_nxt     = short_r;
    if (out_valid_r && out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (report) begin
      pend_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      kth_nxt       = tail_value;
      short_nxt     = !full;
    end else if (ins && in_bus.last_item) begin
      pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r      <= kls_pkg::RANK_W'(1);
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rank_r      <= rank_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    kth_r   <= kth_nxt;
    short_r <= short_nxt;
  end

  // adjacent live entries must stay in non-increasing order
  logic sorted_ok;
  always_comb begin
    sorted_ok = 1'b1;
    for (int i = 1; i < MAX_K; i++) begin
      if (vld_vec[i] && (links[i+1].value > links[i].value)) begin
        sorted_ok = 1'b0;
      end
    end
  end

  a_rise_needs_report: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pend_r))
    else $error("result raised without a closed set");

  a_live_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((vld_vec + 1'b1) & vld_vec) == '0)
    else $error("live cells are not a contiguous prefix");

  a_cleared_after_report: assert property (@(posedge clk) disable iff (!rst_n)
    report |=> (vld_vec == '0))
    else $error("chain not emptied after report");

  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    sorted_ok)
    else $error("chain out of order");

endmodule

`default_nettype wire

// ===== verif/streaming_kth_largest_select_test.sv =====
// self-checking testbench for the streaming k-th largest selector
`default_nettype none

module streaming_kth_largest_select_test;

  localparam int VALUE_W    = kls_pkg::VALUE_W;
  localparam int RANK_W     = kls_pkg::RANK_W;
  localparam int MAX_K      = 16;
  localparam int RAND_BEATS = 1800;
  localparam int SETTLE     = 8;       // extra idle wait, in cycles, once all answers are back
  localparam int IDLE_PCT   = 22;      // percent of cycles a side sits idle

  // one result beat as the block should present it
  typedef struct packed {
    logic signed [VALUE_W-1:0] kth_value;
    logic                      short_set;
  } kth_result_t;

  // running top-k store of the current set plus the queue of pending answers
  class topk_tracker;
    logic [RANK_W-1:0]         rank;
    logic signed [VALUE_W-1:0] kept [MAX_K];
    int unsigned               kept_count;
    kth_result_t               pending_kth [$];
    int                        mismatches;

    function new();
      rank       = RANK_W'(1);
      kept_count = 0;
      mismatches = 0;
      foreach (kept[i]) kept[i] = '0;
    endfunction

    function void set_rank(logic [RANK_W-1:0] r);
      rank = r;
    endfunction

    function int unsigned cap();
      if (rank == 0) return 1;
      if (rank > MAX_K) return MAX_K;
      return rank;
    endfunction

    function int outstanding();
      return pending_kth.size();
    endfunction

    task report(string msg);
      mismatches++;
      $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    // insert one accepted value; on a last beat queue the answer
    function void note_beat(logic signed [VALUE_W-1:0] v, logic last);
      int unsigned k;
      int unsigned pos;
      int unsigned i;
      kth_result_t res;
      k = cap();
      if (kept_count > k) kept_count = k;   // rank lowered mid-set
      pos = 0;
      while (pos < kept_count && kept[pos] >= v) pos++;
      if (pos < k) begin
        i = (kept_count < k) ? kept_count : k - 1;
        while (i > pos) begin
          kept[i] = kept[i-1];
          i--;
        end
        kept[pos] = v;
        if (kept_count < k) kept_count++;
      end
      if (last) begin
        if (kept_count >= k) begin
          res.kth_value = kept[k-1];
          res.short_set = 1'b0;
        end else begin
          res.kth_value = kept[kept_count-1];
          res.short_set = 1'b1;
        end
        pending_kth.push_back(res);
        kept_count = 0;
      end
    endfunction

    task check_result(logic signed [VALUE_W-1:0] kth, logic short_flag);
      kth_result_t exp_res;
      if (pending_kth.size() == 0) begin
        report($sformatf("result %0d/%0b with nothing pending", kth, short_flag));
      end else begin
        exp_res = pending_kth.pop_front();
        if (kth !== exp_res.kth_value)
          report($sformatf("kth_value %0d, want %0d", kth, exp_res.kth_value));
        if (short_flag !== exp_res.short_set)
          report($sformatf("short_set %0b, want %0b", short_flag, exp_res.short_set));
      end
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [RANK_W-1:0] cfg_data;
  logic              calm;         // no idling on either side while set
  int                beats_sent;

  kls_in_if  in_bus ();
  kls_out_if out_bus ();

  topk_tracker tracker = new();

  streaming_kth_largest_select dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_bus   (in_bus),
    .out_bus  (out_bus)
  );

  // 4 time unit clock, high then low
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side back-pressure, changed on the falling edge
  always @(negedge clk) begin
    out_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // result monitor: compare every accepted result beat
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready)
      tracker.check_result(out_bus.kth_value, out_bus.short_set);
  end

  // mix of extremes, tight ranges for duplicates, and full-range values
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return {1'b1, {(VALUE_W-1){1'b0}}};
          1:       return {1'b0, {(VALUE_W-1){1'b1}}};
          2:       return '0;
          default: return '1;
        endcase
      end
      1, 2, 3: return VALUE_W'(int'($urandom_range(0, 8)) - 4);
      default: return $urandom;
    endcase
  endfunction

  // one input beat; called at a falling edge, returns at a falling edge
  // with valid still high so back-to-back beats stay glitch free
  task automatic send_beat(logic signed [VALUE_W-1:0] v, logic last);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.value     <= v;
    in_bus.last_item <= last;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    tracker.note_beat(v, last);
    beats_sent++;
    @(negedge clk);
  endtask

  // park the sender until every answer is back and the chain has settled
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_rank(logic [RANK_W-1:0] r);
    cfg_we   <= 1'b1;
    cfg_data <= r;
    @(posedge clk);
    tracker.set_rank(r);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // random set with a random length; mostly short, now and then past MAX_K
  task automatic send_set(logic close_set);
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_K + 1, 40)
                                      : $urandom_range(1, 18);
    for (int i = 0; i < len; i++)
      send_beat(pick_value(), close_set && (i == len - 1));
  endtask

  initial begin
    int                n_sets;
    logic [RANK_W-1:0] r;

    // every block input known from time zero
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_data         = '0;
    calm             = 1'b0;
    beats_sent       = 0;
    in_bus.valid     = 1'b0;
    in_bus.value     = '0;
    in_bus.last_item = 1'b0;
    out_bus.ready    = 1'b0;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset rank of one, single-beat sets at both extremes
    send_beat(32'sh7fffffff, 1'b1);
    send_beat(32'sh80000000, 1'b1);

    // rank zero behaves as one
    wait_idle();
    write_rank(RANK_W'(0));
    send_beat(32'sd5, 1'b0);
    send_beat(-32'sd3, 1'b0);
    send_beat(32'sd7, 1'b1);

    // oversized rank saturates, short set reports its smallest value
    wait_idle();
    write_rank({RANK_W{1'b1}});
    send_beat(32'sh80000000, 1'b0);
    send_beat(32'sd0, 1'b0);
    send_beat(32'sh7fffffff, 1'b1);

    // duplicates are kept as separate entries
    wait_idle();
    write_rank(RANK_W'(3));
    send_beat(32'sd2, 1'b0);
    send_beat(32'sd2, 1'b0);
    send_beat(32'sd2, 1'b0);
    send_beat(32'sd1, 1'b1);

    // rank lowered in the middle of a set
    wait_idle();
    write_rank(RANK_W'(4));
    send_beat(-32'sd1, 1'b0);
    send_beat(32'sh7fffffff, 1'b0);
    send_beat(32'sh80000000, 1'b0);
    send_beat(32'sd9, 1'b0);
    wait_idle();
    write_rank(RANK_W'(2));
    send_beat(32'sd1, 1'b1);

    // rank raised in the middle of a set
    wait_idle();
    send_beat(32'sd4, 1'b0);
    send_beat(32'sd8, 1'b0);
    wait_idle();
    write_rank(RANK_W'(MAX_K));
    send_beat(-32'sd6, 1'b0);
    send_beat(32'sd3, 1'b1);

    // random phases: new rank each phase, sender drains at every boundary;
    // some phases stop inside a set so the next rank lands mid-set
    beats_sent = 0;
    while (beats_sent < RAND_BEATS) begin
      wait_idle();
      r = ($urandom_range(0, 9) == 0) ? RANK_W'($urandom_range(0, 31))
                                      : RANK_W'($urandom_range(1, MAX_K));
      write_rank(r);
      n_sets = $urandom_range(3, 10);
      for (int s = 0; s < n_sets; s++) begin
        calm = (beats_sent >= 600 && beats_sent < 900);
        send_set(!(s == n_sets - 1 && $urandom_range(0, 5) == 0));
      end
    end
    calm = 1'b0;
    send_beat(pick_value(), 1'b1);   // close any set left open

    wait_idle();
    repeat (SETTLE) @(negedge clk);
    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
